// ===== sv/sdfm_pkg.sv =====
// Shared types, constants and helper functions of the second-derivative focus metric.
`timescale 1ns / 1ps
`default_nettype none

package sdfm_pkg;

  // Frame geometry limits.
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  // Configuration register width and the widths that follow from the limits.
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int WID_W     = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W     = $clog2(MAX_HEIGHT + 1);

  // Pixel format.
  localparam int PIX_W  = 8;
  localparam int NUM_CH = 3;
  localparam int PX_W   = PIX_W * NUM_CH;

  // Second difference arithmetic: 2*c - a - b spans -510..510.
  localparam int DIFF_W = PIX_W + 2;
  localparam int MAG_W  = PIX_W + 1;
  localparam int SQ_W   = 2 * MAG_W;
  localparam int NUM_SQ = 2 * NUM_CH;
  localparam int ADD_W  = SQ_W + 3;

  // Frame sum and fixed-point average.
  localparam int SUM_W  = 43;
  localparam int FRAC_W = 8;
  localparam int AVG_W  = 29;
  localparam int DVD_W  = SUM_W + FRAC_W;
  localparam int DVS_W  = WID_W + HGT_W;
  localparam int CNT_W  = $clog2(DVD_W + 1);

  // Queue between the front end and the back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_e;

  // Divider sequencer states.
  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

  // One classified pixel as it travels from the front end to the back end.
  typedef struct packed {
    logic [PX_W-1:0]  px;
    logic [COL_W-1:0] col;
    logic             interior;
    logic             frame_end;
  } queue_entry_t;

  // Status of the divider toward the back end.
  typedef struct packed {
    logic             done;
    logic [AVG_W-1:0] quotient;
  } div_result_t;

  // Effective width: zero acts as one, large values stop at the limit.
  function automatic logic [WID_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
    logic [WID_W-1:0] r;
    if (v == '0) begin
      r = WID_W'(1);
    end else if (32'(v) > MAX_WIDTH) begin
      r = WID_W'(MAX_WIDTH);
    end else begin
      r = WID_W'(v);
    end
    return r;
  endfunction

  // Effective height: zero acts as one, large values stop at the limit.
  function automatic logic [HGT_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
    logic [HGT_W-1:0] r;
    if (v == '0) begin
      r = HGT_W'(1);
    end else if (32'(v) > MAX_HEIGHT) begin
      r = HGT_W'(MAX_HEIGHT);
    end else begin
      r = HGT_W'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/sdfm_front.sv =====
// Front end: accepts pixels, tracks the raster position and classifies each item.
`timescale 1ns / 1ps
`default_nettype none

module sdfm_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [sdfm_pkg::PIX_W-1:0]   pixel_ch0_i,
  input  wire logic [sdfm_pkg::PIX_W-1:0]   pixel_ch1_i,
  input  wire logic [sdfm_pkg::PIX_W-1:0]   pixel_ch2_i,
  input  wire logic [sdfm_pkg::WID_W-1:0]   width_i,
  input  wire logic [sdfm_pkg::HGT_W-1:0]   height_i,
  input  wire logic                         full_i,
  output logic                              push_o,
  output sdfm_pkg::queue_entry_t            entry_o
);

  logic [sdfm_pkg::COL_W-1:0] col_q, col_d;
  logic [sdfm_pkg::ROW_W-1:0] row_q, row_d;
  logic                       row_end;
  logic                       frame_end;

  // An item is taken whenever the queue has room.
  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  // End of row and end of frame follow the current register values.
  assign row_end   = (sdfm_pkg::WID_W'(col_q) + sdfm_pkg::WID_W'(1)) >= width_i;
  assign frame_end = row_end &&
                     ((sdfm_pkg::HGT_W'(row_q) + sdfm_pkg::HGT_W'(1)) >= height_i);

  // Classified item toward the queue.
  always_comb begin
    entry_o.px        = {pixel_ch2_i, pixel_ch1_i, pixel_ch0_i};
    entry_o.col       = col_q;
    entry_o.interior  = (row_q >= sdfm_pkg::ROW_W'(2)) && (col_q >= sdfm_pkg::COL_W'(2));
    entry_o.frame_end = frame_end;
  end

  // Next raster position.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (row_end) begin
        col_d = '0;
        if (frame_end) begin
          row_d = '0;
        end else begin
          row_d = row_q + sdfm_pkg::ROW_W'(1);
        end
      end else begin
        col_d = col_q + sdfm_pkg::COL_W'(1);
      end
    end
  end

  // Position counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sdfm_queue.sv =====
// Short first-in first-out queue of classified items between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module sdfm_queue (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire sdfm_pkg::queue_entry_t entry_i,
  output logic                        full_o,
  input  wire logic                   pop_i,
  output logic                        valid_o,
  output sdfm_pkg::queue_entry_t      head_o
);

  sdfm_pkg::queue_entry_t      slot_q [sdfm_pkg::QUEUE_DEPTH];
  logic [sdfm_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [sdfm_pkg::QCNT_W-1:0] count_q;

  assign full_o  = count_q == sdfm_pkg::QCNT_W'(sdfm_pkg::QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = slot_q[rd_ptr_q];

  // Storage slots.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + sdfm_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + sdfm_pkg::QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + sdfm_pkg::QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - sdfm_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/sdfm_divider.sv =====
// Restoring divider that turns the frame sum into the per-pixel average, one bit a cycle.
`timescale 1ns / 1ps
`default_nettype none

module sdfm_divider (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [sdfm_pkg::DVD_W-1:0] dividend_i,
  input  wire logic [sdfm_pkg::WID_W-1:0] width_i,
  input  wire logic [sdfm_pkg::HGT_W-1:0] height_i,
  input  wire logic                       ack_i,
  output sdfm_pkg::div_result_t           result_o
);

  sdfm_pkg::div_state_e        state_q, state_d;
  logic [sdfm_pkg::DVD_W-1:0]  quo_q;
  logic [sdfm_pkg::DVS_W-1:0]  rem_q;
  logic [sdfm_pkg::DVS_W-1:0]  dvs_q;
  logic [sdfm_pkg::CNT_W-1:0]  cnt_q;
  logic [sdfm_pkg::DVS_W-1:0]  area;
  logic [sdfm_pkg::DVS_W:0]    shifted;
  logic [sdfm_pkg::DVS_W:0]    trial;
  logic                        last_step;

  // Pixel count of the frame, registered as the divisor at start.
  assign area = sdfm_pkg::DVS_W'(width_i) * sdfm_pkg::DVS_W'(height_i);

  // One restoring step: bring in the next dividend bit and try a subtraction.
  assign shifted   = {rem_q, quo_q[sdfm_pkg::DVD_W-1]};
  assign trial     = shifted - {1'b0, dvs_q};
  assign last_step = cnt_q == sdfm_pkg::CNT_W'(sdfm_pkg::DVD_W - 1);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sdfm_pkg::DIV_IDLE: begin
        if (start_i) begin
          state_d = sdfm_pkg::DIV_RUN;
        end
      end
      sdfm_pkg::DIV_RUN: begin
        if (last_step) begin
          state_d = sdfm_pkg::DIV_DONE;
        end
      end
      sdfm_pkg::DIV_DONE: begin
        if (ack_i) begin
          state_d = sdfm_pkg::DIV_IDLE;
        end
      end
      default: state_d = sdfm_pkg::DIV_IDLE;
    endcase
  end

  // Outputs: the quotient saturates at the width of the average field.
  always_comb begin
    result_o.done = state_q == sdfm_pkg::DIV_DONE;
    if (|quo_q[sdfm_pkg::DVD_W-1:sdfm_pkg::AVG_W]) begin
      result_o.quotient = '1;
    end else begin
      result_o.quotient = quo_q[sdfm_pkg::AVG_W-1:0];
    end
  end

  // Sequencer state and step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdfm_pkg::DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == sdfm_pkg::DIV_RUN) begin
        cnt_q <= cnt_q + sdfm_pkg::CNT_W'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  // Quotient, remainder and divisor.
  always_ff @(posedge clk_i) begin
    if (state_q == sdfm_pkg::DIV_IDLE && start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= area;
    end else if (state_q == sdfm_pkg::DIV_RUN) begin
      if (!trial[sdfm_pkg::DVS_W]) begin
        rem_q <= trial[sdfm_pkg::DVS_W-1:0];
        quo_q <= {quo_q[sdfm_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[sdfm_pkg::DVS_W-1:0];
        quo_q <= {quo_q[sdfm_pkg::DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/sdfm_back.sv =====
// Back end: line stores, 3x3 window, squared second differences, frame sum and result.
`timescale 1ns / 1ps
`default_nettype none

module sdfm_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       q_valid_i,
  input  wire sdfm_pkg::queue_entry_t     q_head_i,
  output logic                            q_pop_o,
  input  wire logic [sdfm_pkg::WID_W-1:0] width_i,
  input  wire logic [sdfm_pkg::HGT_W-1:0] height_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [sdfm_pkg::SUM_W-1:0]      focus_sum_o,
  output logic [sdfm_pkg::AVG_W-1:0]      focus_average_q8_o
);

  // Squared second difference 2*c - a - b of one channel.
  function automatic logic [sdfm_pkg::SQ_W-1:0] sq_diff2(
    input logic [sdfm_pkg::PIX_W-1:0] c,
    input logic [sdfm_pkg::PIX_W-1:0] a,
    input logic [sdfm_pkg::PIX_W-1:0] b
  );
    logic signed [sdfm_pkg::DIFF_W-1:0] d;
    logic        [sdfm_pkg::MAG_W-1:0]  m;
    d = signed'(sdfm_pkg::DIFF_W'({c, 1'b0})) - signed'(sdfm_pkg::DIFF_W'(a))
        - signed'(sdfm_pkg::DIFF_W'(b));
    if (d[sdfm_pkg::DIFF_W-1]) begin
      m = sdfm_pkg::MAG_W'(-d);
    end else begin
      m = sdfm_pkg::MAG_W'(d);
    end
    return sdfm_pkg::SQ_W'(m) * sdfm_pkg::SQ_W'(m);
  endfunction

  // Line stores: the row above (newer) and the row two above (older).
  logic [sdfm_pkg::PX_W-1:0] newer_mem [sdfm_pkg::MAX_WIDTH];
  logic [sdfm_pkg::PX_W-1:0] older_mem [sdfm_pkg::MAX_WIDTH];
  logic [sdfm_pkg::PX_W-1:0] newer_rd_q, older_rd_q;

  // Window stage.
  logic                      busy_q;
  logic                      pop;
  logic                      b1_valid_q;
  sdfm_pkg::queue_entry_t    b1_q;
  logic                      fwd_q;
  logic [sdfm_pkg::PX_W-1:0] last_px_q, last_mid_q;
  logic [sdfm_pkg::PX_W-1:0] mid_now, top_now;
  logic [sdfm_pkg::PX_W-1:0] win_top_q, win_mid_a_q, win_mid_b_q, win_bot_q;
  logic [sdfm_pkg::SQ_W-1:0] sq [sdfm_pkg::NUM_SQ];

  // Accumulate stage.
  logic                      b2_valid_q, b2_interior_q, b2_end_q;
  logic [sdfm_pkg::SQ_W-1:0] sq_q [sdfm_pkg::NUM_SQ];
  logic [sdfm_pkg::ADD_W-1:0] add;
  logic [sdfm_pkg::SUM_W-1:0] acc_q, acc_next, sum_q;

  // Divider and result register.
  logic                        div_start, div_ack;
  sdfm_pkg::div_result_t       div_res;
  logic                        out_valid_q;
  logic [sdfm_pkg::SUM_W-1:0]  out_sum_q;
  logic [sdfm_pkg::AVG_W-1:0]  out_avg_q;

  // An item leaves the queue unless a frame end is still being finished.
  assign pop     = q_valid_i && !busy_q;
  assign q_pop_o = pop;

  // Newer line store: read at pop, written with the current pixel in the cycle after.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      newer_rd_q <= newer_mem[q_head_i.col];
    end
    if (b1_valid_q) begin
      newer_mem[b1_q.col] <= b1_q.px;
    end
  end

  // Older line store: takes over what the newer one held at that column.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      older_rd_q <= older_mem[q_head_i.col];
    end
    if (b1_valid_q) begin
      older_mem[b1_q.col] <= mid_now;
    end
  end

  // A one-pixel-wide frame reads the column that was written in the same cycle.
  assign mid_now = fwd_q ? last_px_q  : newer_rd_q;
  assign top_now = fwd_q ? last_mid_q : older_rd_q;

  // Horizontal and vertical second differences around the middle pixel.
  always_comb begin
    for (int c = 0; c < sdfm_pkg::NUM_CH; c++) begin
      sq[2*c]   = sq_diff2(win_mid_b_q[c*sdfm_pkg::PIX_W +: sdfm_pkg::PIX_W],
                           win_mid_a_q[c*sdfm_pkg::PIX_W +: sdfm_pkg::PIX_W],
                           mid_now[c*sdfm_pkg::PIX_W +: sdfm_pkg::PIX_W]);
      sq[2*c+1] = sq_diff2(win_mid_b_q[c*sdfm_pkg::PIX_W +: sdfm_pkg::PIX_W],
                           win_top_q[c*sdfm_pkg::PIX_W +: sdfm_pkg::PIX_W],
                           win_bot_q[c*sdfm_pkg::PIX_W +: sdfm_pkg::PIX_W]);
    end
  end

  // Payload of the window and accumulate stages.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      b1_q <= q_head_i;
    end
    if (b1_valid_q) begin
      last_px_q  <= b1_q.px;
      last_mid_q <= mid_now;
      sq_q       <= sq;
    end
    if (b2_valid_q && b2_end_q) begin
      sum_q <= acc_next;
    end
  end

  // Stage control and window registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q    <= 1'b0;
      fwd_q         <= 1'b0;
      b2_valid_q    <= 1'b0;
      b2_interior_q <= 1'b0;
      b2_end_q      <= 1'b0;
      win_top_q     <= '0;
      win_mid_a_q   <= '0;
      win_mid_b_q   <= '0;
      win_bot_q     <= '0;
    end else begin
      b1_valid_q <= pop;
      fwd_q      <= pop && b1_valid_q && (b1_q.col == q_head_i.col);
      b2_valid_q <= b1_valid_q;
      if (b1_valid_q) begin
        b2_interior_q <= b1_q.interior;
        b2_end_q      <= b1_q.frame_end;
        win_top_q     <= top_now;
        win_mid_a_q   <= win_mid_b_q;
        win_mid_b_q   <= mid_now;
        win_bot_q     <= b1_q.px;
      end
    end
  end

  // Sum of the six squares of one interior pixel.
  always_comb begin
    add = '0;
    for (int i = 0; i < sdfm_pkg::NUM_SQ; i++) begin
      add = add + sdfm_pkg::ADD_W'(sq_q[i]);
    end
  end

  assign acc_next = b2_interior_q ? acc_q + sdfm_pkg::SUM_W'(add) : acc_q;

  // Frame accumulator, cleared as the frame's result goes to the divider.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (b2_valid_q) begin
      if (b2_end_q) begin
        acc_q <= '0;
      end else begin
        acc_q <= acc_next;
      end
    end
  end

  assign div_start = b2_valid_q && b2_end_q;
  assign div_ack   = div_res.done && (!out_valid_q || out_ready_i);

  sdfm_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({acc_next, {sdfm_pkg::FRAC_W{1'b0}}}),
    .width_i    (width_i),
    .height_i   (height_i),
    .ack_i      (div_ack),
    .result_o   (div_res)
  );

  // The back end holds off new items from a frame end until its result is registered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop && q_head_i.frame_end) begin
        busy_q <= 1'b1;
      end else if (div_ack) begin
        busy_q <= 1'b0;
      end
      if (div_ack) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (div_ack) begin
      out_sum_q <= sum_q;
      out_avg_q <= div_res.quotient;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign focus_sum_o        = out_sum_q;
  assign focus_average_q8_o = out_avg_q;

endmodule

`default_nettype wire

// ===== sv/second_derivative_focus_metric.sv =====
// Top level of the second-derivative focus metric: configuration, front end, queue, back end.
`timescale 1ns / 1ps
`default_nettype none

// Computes a focus score over a raster-order stream of three-channel 8-bit pixels.
// For every interior pixel and channel the squared horizontal and vertical second
// differences are summed; after the last pixel of a frame one item carries the sum
// and the sum divided by width*height (8 fraction bits, truncated, saturated to 29
// bits). Within a frame one pixel is accepted per clock while the queue has room. At each
// frame end the back end holds the queue after taking the frame's last pixel, through
// two pipeline stages, a 51-step restoring divider that produces one quotient bit per cycle,
// and the result load; the four-entry queue keeps taking pixels meanwhile and then the
// input stalls until the result is loaded.
// Width and height are clamped into 1..2048, a value of zero acts as one, and they are
// to be written only while the block is idle, which the block itself does not enforce.
// The two line stores need no clearing.
module second_derivative_focus_metric (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [sdfm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [sdfm_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [sdfm_pkg::PIX_W-1:0]     pixel_ch0_i,
  input  wire logic [sdfm_pkg::PIX_W-1:0]     pixel_ch1_i,
  input  wire logic [sdfm_pkg::PIX_W-1:0]     pixel_ch2_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [sdfm_pkg::SUM_W-1:0]          focus_sum_o,
  output logic [sdfm_pkg::AVG_W-1:0]          focus_average_q8_o
);

  logic [sdfm_pkg::CFG_W-1:0] width_q, height_q;
  logic [sdfm_pkg::WID_W-1:0] width_eff;
  logic [sdfm_pkg::HGT_W-1:0] height_eff;

  logic                       push, full, q_valid, q_pop;
  sdfm_pkg::queue_entry_t     entry, q_head;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sdfm_pkg::WIDTH_RESET;
      height_q <= sdfm_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sdfm_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        sdfm_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign width_eff  = sdfm_pkg::clamp_width(width_q);
  assign height_eff = sdfm_pkg::clamp_height(height_q);

  sdfm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_ch0_i (pixel_ch0_i),
    .pixel_ch1_i (pixel_ch1_i),
    .pixel_ch2_i (pixel_ch2_i),
    .width_i     (width_eff),
    .height_i    (height_eff),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (entry)
  );

  sdfm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  sdfm_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .q_head_i           (q_head),
    .q_pop_o            (q_pop),
    .width_i            (width_eff),
    .height_i           (height_eff),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .focus_sum_o        (focus_sum_o),
    .focus_average_q8_o (focus_average_q8_o)
  );

  // An accepted pixel is waiting in the queue in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> q_valid)
    else $error("accepted item did not reach the queue");

  // After a frame end leaves the queue, the back end holds until the result is formed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid && q_pop && q_head.frame_end) |=> !q_pop)
    else $error("back end took an item while finishing a frame");

  // The average can never exceed the sum in the same fixed-point scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      ({{(sdfm_pkg::DVD_W - sdfm_pkg::AVG_W){1'b0}}, focus_average_q8_o} <=
       {focus_sum_o, {sdfm_pkg::FRAC_W{1'b0}}}))
    else $error("average exceeds the frame sum");

endmodule

`default_nettype wire

// ===== tb/sdfm_score_checker.sv =====
// Checker for the focus metric: predicts each frame's score from the pixel items and compares.
`timescale 1ns / 1ps
`default_nettype none

module sdfm_score_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [sdfm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [sdfm_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  input  wire logic                           in_ready_i,
  input  wire logic [sdfm_pkg::PIX_W-1:0]     pixel_ch0_i,
  input  wire logic [sdfm_pkg::PIX_W-1:0]     pixel_ch1_i,
  input  wire logic [sdfm_pkg::PIX_W-1:0]     pixel_ch2_i,
  input  wire logic                           out_valid_i,
  input  wire logic                           out_ready_i,
  input  wire logic [sdfm_pkg::SUM_W-1:0]     focus_sum_i,
  input  wire logic [sdfm_pkg::AVG_W-1:0]     focus_average_q8_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);

  localparam int          ENERGY_W   = 48;
  localparam logic [63:0] ENERGY_MAX = (64'd1 << ENERGY_W) - 64'd1;
  localparam logic [63:0] SUM_MAX    = (64'd1 << sdfm_pkg::SUM_W) - 64'd1;
  localparam logic [63:0] AVG_MAX    = (64'd1 << sdfm_pkg::AVG_W) - 64'd1;

  // One frame score as the block should deliver it.
  typedef struct packed {
    logic [sdfm_pkg::SUM_W-1:0] sum;
    logic [sdfm_pkg::AVG_W-1:0] avg;
  } frame_score_t;

  // Predicted pipeline state: two row stores, the 3x2 window, position and running energy.
  logic [sdfm_pkg::PX_W-1:0]  older_row [sdfm_pkg::MAX_WIDTH];
  logic [sdfm_pkg::PX_W-1:0]  newer_row [sdfm_pkg::MAX_WIDTH];
  logic [sdfm_pkg::PX_W-1:0]  win [6];
  int unsigned                col_pos;
  int unsigned                row_pos;
  logic [ENERGY_W-1:0]        frame_energy;
  logic [sdfm_pkg::CFG_W-1:0] width_reg;
  logic [sdfm_pkg::CFG_W-1:0] height_reg;
  frame_score_t               pending_scores [$];
  int                         mismatch_total;

  assign fail_count_o = mismatch_total;

  // Effective dimension: zero acts as one, large values stop at the limit.
  function automatic int unsigned effective_dim(input logic [sdfm_pkg::CFG_W-1:0] v,
                                                input int unsigned lim);
    int unsigned r;
    r = v;
    if (r == 0) r = 1;
    if (r > lim) r = lim;
    return r;
  endfunction

  // Square of 2*centre - a - b for one channel.
  function automatic logic [63:0] curvature_sq(input logic [sdfm_pkg::PIX_W-1:0] ctr,
                                               input logic [sdfm_pkg::PIX_W-1:0] a,
                                               input logic [sdfm_pkg::PIX_W-1:0] b);
    int d;
    d = 2 * int'(ctr) - int'(a) - int'(b);
    if (d < 0) d = -d;
    return 64'(d * d);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_total++;
  endtask

  // Advance the predicted state by one pixel item; queue a score at frame end.
  task automatic advance_pixel(input logic [sdfm_pkg::PX_W-1:0] px);
    int unsigned               w;
    int unsigned               h;
    int unsigned               col;
    int                        ch;
    logic [sdfm_pkg::PX_W-1:0] top_now;
    logic [sdfm_pkg::PX_W-1:0] mid_now;
    logic [sdfm_pkg::PIX_W-1:0] ctr;
    logic [63:0]               total;
    logic [63:0]               avg;
    frame_score_t              score;
    w = effective_dim(width_reg, sdfm_pkg::MAX_WIDTH);
    h = effective_dim(height_reg, sdfm_pkg::MAX_HEIGHT);
    col = (col_pos < sdfm_pkg::MAX_WIDTH) ? col_pos : sdfm_pkg::MAX_WIDTH - 1;
    top_now = older_row[col];
    mid_now = newer_row[col];

    // The pixel one row up and one column left is the centre of the window.
    if (row_pos >= 2 && col >= 2) begin
      total = 64'(frame_energy);
      for (ch = 0; ch < sdfm_pkg::NUM_CH; ch++) begin
        ctr = win[3][ch*sdfm_pkg::PIX_W +: sdfm_pkg::PIX_W];
        total += curvature_sq(ctr, win[2][ch*sdfm_pkg::PIX_W +: sdfm_pkg::PIX_W],
                              mid_now[ch*sdfm_pkg::PIX_W +: sdfm_pkg::PIX_W]);
        total += curvature_sq(ctr, win[1][ch*sdfm_pkg::PIX_W +: sdfm_pkg::PIX_W],
                              win[5][ch*sdfm_pkg::PIX_W +: sdfm_pkg::PIX_W]);
      end
      if (total > ENERGY_MAX) total = ENERGY_MAX;
      frame_energy = total[ENERGY_W-1:0];
    end

    win[0] = win[1];
    win[1] = top_now;
    win[2] = win[3];
    win[3] = mid_now;
    win[4] = win[5];
    win[5] = px;
    older_row[col] = mid_now;
    newer_row[col] = px;

    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) begin
        total = 64'(frame_energy);
        avg = (total << sdfm_pkg::FRAC_W) / (64'(w) * 64'(h));
        score.sum = (total > SUM_MAX) ? SUM_MAX[sdfm_pkg::SUM_W-1:0]
                                      : total[sdfm_pkg::SUM_W-1:0];
        score.avg = (avg > AVG_MAX) ? AVG_MAX[sdfm_pkg::AVG_W-1:0]
                                    : avg[sdfm_pkg::AVG_W-1:0];
        pending_scores.push_back(score);
        row_pos = 0;
        frame_energy = '0;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
  endtask

  // Watch both channels and the configuration port at every edge.
  always @(posedge clk_i or negedge rst_ni) begin
    frame_score_t want;
    if (!rst_ni) begin
      for (int i = 0; i < sdfm_pkg::MAX_WIDTH; i++) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      for (int i = 0; i < 6; i++) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      frame_energy = '0;
      width_reg = sdfm_pkg::WIDTH_RESET;
      height_reg = sdfm_pkg::HEIGHT_RESET;
      pending_scores.delete();
      mismatch_total = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (sdfm_pkg::cfg_index_e'(cfg_index_i))
          sdfm_pkg::CFG_FRAME_WIDTH: begin
            width_reg = cfg_data_i;
          end
          sdfm_pkg::CFG_FRAME_HEIGHT: begin
            height_reg = cfg_data_i;
          end
          default: begin
          end
        endcase
      end

      // Compare a delivered score against the oldest prediction.
      if (out_valid_i && out_ready_i) begin
        if (pending_scores.size() == 0) begin
          report_mismatch($sformatf("score with no frame pending: sum %0d avg %0d",
                                    focus_sum_i, focus_average_q8_i));
        end else begin
          want = pending_scores.pop_front();
          if (focus_sum_i !== want.sum) begin
            report_mismatch($sformatf("focus_sum got %0d want %0d", focus_sum_i, want.sum));
          end
          if (focus_average_q8_i !== want.avg) begin
            report_mismatch($sformatf("focus_average_q8 got %0d want %0d",
                                      focus_average_q8_i, want.avg));
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        advance_pixel({pixel_ch2_i, pixel_ch1_i, pixel_ch0_i});
      end
      pending_o <= pending_scores.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_second_derivative_focus_metric.sv =====
// Testbench top for the focus metric: clock, reset, pixel stimulus, configuration and verdict.
`timescale 1ns / 1ps
`default_nettype none

module tb_second_derivative_focus_metric;

  localparam int RANDOM_ITEMS  = 1800;
  localparam int RANDOM_FRAMES = 48;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int IDLE_PCT      = 14;

  // Pixel patterns used to fill a frame.
  typedef enum int {
    PAT_RANDOM,
    PAT_EXTREME,
    PAT_CHECKER,
    PAT_SMOOTH,
    PAT_ALL_MAX,
    PAT_SPLIT
  } pattern_e;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [sdfm_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [sdfm_pkg::CFG_W-1:0]     cfg_data_i;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic [sdfm_pkg::PIX_W-1:0]     pixel_ch0_i;
  logic [sdfm_pkg::PIX_W-1:0]     pixel_ch1_i;
  logic [sdfm_pkg::PIX_W-1:0]     pixel_ch2_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [sdfm_pkg::SUM_W-1:0]     focus_sum_o;
  logic [sdfm_pkg::AVG_W-1:0]     focus_average_q8_o;

  int                             fail_count;
  int                             frames_pending;
  int                             scores_taken;
  int                             cycle_count;
  logic                           steady_sender;
  logic [sdfm_pkg::CFG_W-1:0]     width_setting;
  logic [sdfm_pkg::CFG_W-1:0]     height_setting;

  second_derivative_focus_metric dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .pixel_ch0_i        (pixel_ch0_i),
    .pixel_ch1_i        (pixel_ch1_i),
    .pixel_ch2_i        (pixel_ch2_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .focus_sum_o        (focus_sum_o),
    .focus_average_q8_o (focus_average_q8_o)
  );

  sdfm_score_checker checker_inst (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_i         (in_ready_o),
    .pixel_ch0_i        (pixel_ch0_i),
    .pixel_ch1_i        (pixel_ch1_i),
    .pixel_ch2_i        (pixel_ch2_i),
    .out_valid_i        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .focus_sum_i        (focus_sum_o),
    .focus_average_q8_i (focus_average_q8_o),
    .fail_count_o       (fail_count),
    .pending_o          (frames_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Score receiver: stalls at random, except while the score count is in a steady window.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      scores_taken <= 0;
    end else begin
      if (out_valid_o && out_ready_i) scores_taken <= scores_taken + 1;
      out_ready_i <= (scores_taken >= 20 && scores_taken < 45) ||
                     ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Present one pixel item and hold it until it is taken.
  task automatic send_pixel(input logic [sdfm_pkg::PX_W-1:0] px);
    while (!steady_sender && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_ch0_i <= px[0*sdfm_pkg::PIX_W +: sdfm_pkg::PIX_W];
    pixel_ch1_i <= px[1*sdfm_pkg::PIX_W +: sdfm_pkg::PIX_W];
    pixel_ch2_i <= px[2*sdfm_pkg::PIX_W +: sdfm_pkg::PIX_W];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stop sending and wait until every predicted score has been delivered.
  task automatic wait_for_scores();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frames_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write both dimensions; only called while the block is idle.
  task automatic set_dims(input logic [sdfm_pkg::CFG_W-1:0] w,
                          input logic [sdfm_pkg::CFG_W-1:0] h);
    cfg_we_i <= 1'b1;
    cfg_index_i <= sdfm_pkg::CFG_FRAME_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_index_i <= sdfm_pkg::CFG_FRAME_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    width_setting = w;
    height_setting = h;
  endtask

  // Pixel value of a pattern at one raster position.
  function automatic logic [sdfm_pkg::PX_W-1:0] pattern_pixel(
    input pattern_e pat, input int r, input int c, input logic [sdfm_pkg::PX_W-1:0] base
  );
    logic [sdfm_pkg::PX_W-1:0] px;
    int                        ch;
    px = '0;
    case (pat)
      PAT_EXTREME: begin
        for (ch = 0; ch < sdfm_pkg::NUM_CH; ch++) begin
          px[ch*sdfm_pkg::PIX_W +: sdfm_pkg::PIX_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
      end
      PAT_CHECKER: begin
        px = ((r + c) % 2 == 1) ? {sdfm_pkg::PX_W{1'b1}} : '0;
      end
      PAT_SMOOTH: begin
        for (ch = 0; ch < sdfm_pkg::NUM_CH; ch++) begin
          px[ch*sdfm_pkg::PIX_W +: sdfm_pkg::PIX_W] =
            base[ch*sdfm_pkg::PIX_W +: sdfm_pkg::PIX_W] +
            sdfm_pkg::PIX_W'($urandom_range(0, 3));
        end
      end
      PAT_ALL_MAX: begin
        px = {sdfm_pkg::PX_W{1'b1}};
      end
      PAT_SPLIT: begin
        px = {sdfm_pkg::PIX_W'($urandom_range(0, 255)), 8'h00, 8'hFF};
      end
      default: begin
        px = sdfm_pkg::PX_W'($urandom);
      end
    endcase
    return px;
  endfunction

  // Send one whole frame at the current dimensions; returns its pixel count.
  task automatic send_frame(input pattern_e pat, output int count);
    int                        w;
    int                        h;
    logic [sdfm_pkg::PX_W-1:0] base;
    w = sdfm_pkg::clamp_width(width_setting);
    h = sdfm_pkg::clamp_height(height_setting);
    base = sdfm_pkg::PX_W'($urandom) & 24'hFCFCFC;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) send_pixel(pattern_pixel(pat, r, c, base));
    end
    count = w * h;
  endtask

  // Random dimension, mostly small so that frames end often.
  function automatic logic [sdfm_pkg::CFG_W-1:0] pick_dim();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return '0;
    if (roll < 83) return sdfm_pkg::CFG_W'($urandom_range(1, 8));
    return sdfm_pkg::CFG_W'($urandom_range(9, 24));
  endfunction

  initial begin
    int random_items;
    int random_frames;
    int phase;
    int frames;
    int count;
    steady_sender = 1'b0;
    width_setting = sdfm_pkg::WIDTH_RESET;
    height_setting = sdfm_pkg::HEIGHT_RESET;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= sdfm_pkg::CFG_FRAME_WIDTH;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    pixel_ch0_i <= '0;
    pixel_ch1_i <= '0;
    pixel_ch2_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames: maximal curvature, a zero-sized setting, a tiny frame, fixed channels.
    set_dims(12'd3, 12'd3);
    send_frame(PAT_CHECKER, count);
    wait_for_scores();
    set_dims(12'd0, 12'd0);
    send_frame(PAT_ALL_MAX, count);
    wait_for_scores();
    set_dims(12'd2, 12'd2);
    send_frame(PAT_RANDOM, count);
    wait_for_scores();
    set_dims(12'd3, 12'd3);
    send_frame(PAT_SPLIT, count);
    wait_for_scores();

    // Random phases, with a few long and thin frame shapes.
    random_items = 0;
    random_frames = 0;
    phase = 0;
    while (random_items < RANDOM_ITEMS || random_frames < RANDOM_FRAMES) begin
      case (phase)
        3: begin
          set_dims(12'd40, 12'd3);
          send_frame(PAT_CHECKER, count);
          random_items += count;
          random_frames++;
        end
        8: begin
          set_dims(12'd3, 12'd40);
          send_frame(PAT_RANDOM, count);
          random_items += count;
          random_frames++;
        end
        13: begin
          set_dims(12'd1, 12'd30);
          send_frame(PAT_EXTREME, count);
          random_items += count;
          random_frames++;
        end
        18: begin
          set_dims(12'd30, 12'd1);
          send_frame(PAT_RANDOM, count);
          random_items += count;
          random_frames++;
        end
        default: begin
          if (phase == 0 || $urandom_range(0, 3) != 0) set_dims(pick_dim(), pick_dim());
          frames = $urandom_range(1, 4);
          repeat (frames) begin
            steady_sender = (random_items >= 700 && random_items < 1100);
            send_frame(pattern_e'($urandom_range(PAT_RANDOM, PAT_SMOOTH)), count);
            random_items += count;
            random_frames++;
            // Sometimes hold off the next frame until the scores so far are in.
            if ($urandom_range(0, 3) == 0) wait_for_scores();
          end
        end
      endcase
      wait_for_scores();
      phase++;
    end
    steady_sender = 1'b0;

    wait_for_scores();
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/sdfm_pkg.sv
sv/sdfm_front.sv
sv/sdfm_queue.sv
sv/sdfm_divider.sv
sv/sdfm_back.sv
sv/second_derivative_focus_metric.sv
tb/sdfm_score_checker.sv
tb/tb_second_derivative_focus_metric.sv
